### sv/mjdc_pkg.sv
// ----------------------------------------------------------------------------
// mjdc_pkg
// Shared types, constants and lookup tables for the MJD to calendar date
// converter.
// ----------------------------------------------------------------------------
package mjdc_pkg;

	// Accepted day number range; inputs outside it are clamped
	localparam logic signed [22:0] MJD_LO = -23'sd2400000;
	localparam logic signed [22:0] MJD_HI = 23'sd2973483;

	// Chronological day offset and first Gregorian day
	localparam logic [22:0] JD_OFFSET  = 23'd2400001;
	localparam logic [22:0] GREG_START = 23'd2299161;

	// Reciprocals for exact floor division by constants: ceil(2^K / D)
	localparam int CENT_SH  = 43;  // divide by 146097, numerator < 2^25
	localparam int YEAR_SH  = 40;  // divide by 7305, numerator < 2^27
	localparam int MONTH_SH = 42;  // divide by 306001, numerator < 2^23
	localparam int WDAY_SH  = 26;  // divide by 7, numerator < 2^23
	localparam int D25_SH   = 19;  // divide by 25, numerator < 2^14
	localparam int WEEK_SH  = 12;  // divide by 7, numerator < 2^9

	localparam logic [25:0] RECIP_CENT  =
		26'(((64'd1 << CENT_SH) + 64'd146096) / 64'd146097);
	localparam logic [27:0] RECIP_YEAR  =
		28'(((64'd1 << YEAR_SH) + 64'd7304) / 64'd7305);
	localparam logic [23:0] RECIP_MONTH =
		24'(((64'd1 << MONTH_SH) + 64'd306000) / 64'd306001);
	localparam logic [23:0] RECIP_WDAY  =
		24'(((64'd1 << WDAY_SH) + 64'd6) / 64'd7);
	localparam logic [14:0] RECIP_D25   =
		15'(((64'd1 << D25_SH) + 64'd24) / 64'd25);
	localparam logic [9:0]  RECIP_WEEK  =
		10'(((64'd1 << WEEK_SH) + 64'd6) / 64'd7);

	// Calendar date passed between the two halves of the pipeline
	typedef struct packed {
		logic signed [14:0] year;
		logic [3:0]         month;
		logic [4:0]         dom;
		logic [2:0]         wday;
	} mjdc_date_t;

	// floor(306001 * e / 10000) for the month index e
	function automatic logic [8:0] month_span(input logic [3:0] e);
		logic [8:0] v;
		unique case (e)
			4'd0:    v = 9'd0;
			4'd1:    v = 9'd30;
			4'd2:    v = 9'd61;
			4'd3:    v = 9'd91;
			4'd4:    v = 9'd122;
			4'd5:    v = 9'd153;
			4'd6:    v = 9'd183;
			4'd7:    v = 9'd214;
			4'd8:    v = 9'd244;
			4'd9:    v = 9'd275;
			4'd10:   v = 9'd306;
			4'd11:   v = 9'd336;
			4'd12:   v = 9'd367;
			4'd13:   v = 9'd397;
			4'd14:   v = 9'd428;
			default: v = 9'd459;
		endcase
		return v;
	endfunction

	// floor(275 * m / 9) - 30 for month m
	function automatic logic [8:0] month_base(input logic [3:0] m);
		logic [8:0] v;
		unique case (m)
			4'd1:    v = 9'd0;
			4'd2:    v = 9'd31;
			4'd3:    v = 9'd61;
			4'd4:    v = 9'd92;
			4'd5:    v = 9'd122;
			4'd6:    v = 9'd153;
			4'd7:    v = 9'd183;
			4'd8:    v = 9'd214;
			4'd9:    v = 9'd245;
			4'd10:   v = 9'd275;
			4'd11:   v = 9'd306;
			4'd12:   v = 9'd336;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

endpackage

### sv/mjdc_day_split.sv
// ----------------------------------------------------------------------------
// mjdc_day_split
// Nine-stage pipeline: clamps the day number and splits it into year,
// month, day of month and weekday (Julian / Gregorian switch included).
// ----------------------------------------------------------------------------
module mjdc_day_split (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [22:0]       in_mjd,
	output logic                     out_valid,
	input  logic                     out_ready,
	output mjdc_pkg::mjdc_date_t     out_date
);

	localparam int N = 9;

	logic [N:1]   vld_q;
	logic [N+1:1] adv;
	logic [N:1]   vld_in;

	// Stage advance: a stage moves when empty or when the next one moves
	always_comb begin
		adv[N+1] = out_ready;
		for (int k = N; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign vld_in   = {vld_q[N-1:1], in_valid};
	assign in_ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (adv[N:1] & vld_in) | (~adv[N:1] & vld_q);
		end
	end

	// Stage 1: clamp, chronological day z
	logic signed [22:0] mjd_clamp;
	logic [22:0]        z_s1;

	always_comb begin
		if (in_mjd < mjdc_pkg::MJD_LO) begin
			mjd_clamp = mjdc_pkg::MJD_LO;
		end else if (in_mjd > mjdc_pkg::MJD_HI) begin
			mjd_clamp = mjdc_pkg::MJD_HI;
		end else begin
			mjd_clamp = in_mjd;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			z_s1 <= $unsigned(mjd_clamp) + mjdc_pkg::JD_OFFSET;
		end
	end

	// Stage 2: century count and z / 7 by reciprocal multiply
	logic [24:0] cent_num;
	logic [50:0] cent_prod;
	logic [46:0] wk_prod;
	logic [22:0] z_s2;
	logic        greg_s2;
	logic [6:0]  al_s2;
	logic [19:0] zq7_s2;

	assign cent_num  = {z_s1, 2'b00} - 25'd7468865;
	assign cent_prod = 51'(cent_num) * 51'(mjdc_pkg::RECIP_CENT);
	assign wk_prod   = 47'(z_s1) * 47'(mjdc_pkg::RECIP_WDAY);

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			z_s2    <= z_s1;
			greg_s2 <= (z_s1 >= mjdc_pkg::GREG_START);
			al_s2   <= cent_prod[mjdc_pkg::CENT_SH+6:mjdc_pkg::CENT_SH];
			zq7_s2  <= wk_prod[mjdc_pkg::WDAY_SH+19:mjdc_pkg::WDAY_SH];
		end
	end

	// Stage 3: Gregorian correction to b, weekday from z mod 7
	logic [7:0]  greg_corr;
	logic [22:0] seven_q;
	logic [22:0] z_rem;
	logic [22:0] b_s3;
	logic [2:0]  wday_s3;

	assign greg_corr = 8'd1 + {1'b0, al_s2} - {3'b000, al_s2[6:2]};
	assign seven_q   = {zq7_s2, 3'b000} - {3'b000, zq7_s2};
	assign z_rem     = z_s2 - seven_q;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			b_s3    <= z_s2 + 23'd1524 + (greg_s2 ? {15'b0, greg_corr} : 23'd0);
			wday_s3 <= z_rem[2:0] + 3'd1;
		end
	end

	// Stage 4: year numerator 20b - 2442
	logic [26:0] n2_s4;
	logic [22:0] b_s4;
	logic [2:0]  wday_s4;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			n2_s4   <= {4'b0, b_s3} * 27'd20 - 27'd2442;
			b_s4    <= b_s3;
			wday_s4 <= wday_s3;
		end
	end

	// Stage 5: year count c = n2 / 7305
	logic [54:0] year_prod;
	logic [13:0] c_s5;
	logic [22:0] b_s5;
	logic [2:0]  wday_s5;

	assign year_prod = 55'(n2_s4) * 55'(mjdc_pkg::RECIP_YEAR);

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			c_s5    <= year_prod[mjdc_pkg::YEAR_SH+13:mjdc_pkg::YEAR_SH];
			b_s5    <= b_s4;
			wday_s5 <= wday_s4;
		end
	end

	// Stage 6: days left in the year, b - floor(1461c / 4)
	logic [24:0] days_prod;
	logic [22:0] bd_diff;
	logic [8:0]  bd_s6;
	logic [13:0] c_s6;
	logic [2:0]  wday_s6;

	assign days_prod = {11'b0, c_s5} * 25'd1461;
	assign bd_diff   = b_s5 - days_prod[24:2];

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			bd_s6   <= bd_diff[8:0];
			c_s6    <= c_s5;
			wday_s6 <= wday_s5;
		end
	end

	// Stage 7: month numerator 10000 * bd
	logic [22:0] n4_s7;
	logic [8:0]  bd_s7;
	logic [13:0] c_s7;
	logic [2:0]  wday_s7;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			n4_s7   <= {14'b0, bd_s6} * 23'd10000;
			bd_s7   <= bd_s6;
			c_s7    <= c_s6;
			wday_s7 <= wday_s6;
		end
	end

	// Stage 8: month index e = n4 / 306001
	logic [46:0] month_prod;
	logic [3:0]  e_s8;
	logic [8:0]  bd_s8;
	logic [13:0] c_s8;
	logic [2:0]  wday_s8;

	assign month_prod = 47'(n4_s7) * 47'(mjdc_pkg::RECIP_MONTH);

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			e_s8    <= month_prod[mjdc_pkg::MONTH_SH+3:mjdc_pkg::MONTH_SH];
			bd_s8   <= bd_s7;
			c_s8    <= c_s7;
			wday_s8 <= wday_s7;
		end
	end

	// Stage 9: day of month, month and year
	logic [8:0]           dom_full;
	logic [3:0]           month_nxt;
	logic [14:0]          year_nxt;
	mjdc_pkg::mjdc_date_t date_s9;

	assign dom_full  = bd_s8 - mjdc_pkg::month_span(e_s8);
	assign month_nxt = (e_s8 < 4'd14) ? e_s8 - 4'd1 : e_s8 - 4'd13;
	assign year_nxt  = {1'b0, c_s8} - 15'd4715 - {14'b0, (month_nxt > 4'd2)};

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			date_s9.year  <= $signed(year_nxt);
			date_s9.month <= month_nxt;
			date_s9.dom   <= dom_full[4:0];
			date_s9.wday  <= wday_s8;
		end
	end

	assign out_valid = vld_q[N];
	assign out_date  = date_s9;

endmodule

### sv/mjdc_date_fields.sv
// ----------------------------------------------------------------------------
// mjdc_date_fields
// Four-stage pipeline: day of year, week number and packed yyyymmdd from a
// calendar date. Its last stage is the block's output register.
// ----------------------------------------------------------------------------
module mjdc_date_fields (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mjdc_pkg::mjdc_date_t in_date,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [14:0]   year,
	output logic [3:0]           month,
	output logic [4:0]           day_of_month,
	output logic [2:0]           weekday,
	output logic [8:0]           day_of_year,
	output logic [5:0]           week_of_year,
	output logic signed [27:0]   packed_date
);

	localparam int N = 4;

	logic [N:1]   vld_q;
	logic [N+1:1] adv;
	logic [N:1]   vld_in;

	// Stage advance, same scheme as the front half
	always_comb begin
		adv[N+1] = out_ready;
		for (int k = N; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign vld_in   = {vld_q[N-1:1], in_valid};
	assign in_ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (adv[N:1] & vld_in) | (~adv[N:1] & vld_q);
		end
	end

	// Stage 1: year offset by 4800 (multiple of 400) for the leap test,
	// |year| * 10000, month/day part and day-of-year base
	logic [14:0]          yoff_full;
	logic [28:0]          d25_prod;
	logic [14:0]          year_abs;
	mjdc_pkg::mjdc_date_t date_s1;
	logic [13:0]          yoff_s1;
	logic [9:0]           q25_s1;
	logic [26:0]          ay10k_s1;
	logic [10:0]          md_s1;
	logic [8:0]           base_s1;

	assign yoff_full = $unsigned(in_date.year) + 15'd4800;
	assign d25_prod  = 29'(yoff_full[13:0]) * 29'(mjdc_pkg::RECIP_D25);
	assign year_abs  = in_date.year[14] ? 15'd0 - $unsigned(in_date.year)
	                                    : $unsigned(in_date.year);

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			date_s1  <= in_date;
			yoff_s1  <= yoff_full[13:0];
			q25_s1   <= d25_prod[mjdc_pkg::D25_SH+9:mjdc_pkg::D25_SH];
			ay10k_s1 <= {13'b0, year_abs[13:0]} * 27'd10000;
			md_s1    <= {7'b0, in_date.month} * 11'd100 + {6'b0, in_date.dom};
			base_s1  <= mjdc_pkg::month_base(in_date.month) + {4'b0, in_date.dom};
		end
	end

	// Stage 2: leap year (Gregorian rule), day of year, packed date
	logic [14:0]          q25_x25;
	logic                 div4;
	logic                 div16;
	logic                 div25;
	logic                 leap;
	logic [8:0]           feb_adj;
	logic [26:0]          pk_mag;
	mjdc_pkg::mjdc_date_t date_s2;
	logic [8:0]           doy_s2;
	logic signed [27:0]   packed_s2;

	assign q25_x25 = {5'b0, q25_s1} * 15'd25;
	assign div25   = (q25_x25 == {1'b0, yoff_s1});
	assign div4    = (yoff_s1[1:0] == 2'b00);
	assign div16   = (yoff_s1[3:0] == 4'b0000);
	assign leap    = div4 && (!div25 || div16);
	assign feb_adj = (date_s1.month > 4'd2) ? (leap ? 9'd1 : 9'd2) : 9'd0;
	assign pk_mag  = ay10k_s1 + {16'b0, md_s1};

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			date_s2   <= date_s1;
			doy_s2    <= base_s1 - feb_adj;
			packed_s2 <= date_s1.year[14] ? $signed(28'd0 - {1'b0, pk_mag})
			                              : $signed({1'b0, pk_mag});
		end
	end

	// Stage 3: week base (doy + 3) / 7
	logic [8:0]           p_nxt;
	logic [17:0]          wk_prod;
	mjdc_pkg::mjdc_date_t date_s3;
	logic [8:0]           doy_s3;
	logic signed [27:0]   packed_s3;
	logic [8:0]           p_s3;
	logic [5:0]           wk0_s3;

	assign p_nxt   = doy_s2 + 9'd3;
	assign wk_prod = {9'b0, p_nxt} * 18'(mjdc_pkg::RECIP_WEEK);

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			date_s3   <= date_s2;
			doy_s3    <= doy_s2;
			packed_s3 <= packed_s2;
			p_s3      <= p_nxt;
			wk0_s3    <= wk_prod[mjdc_pkg::WEEK_SH+5:mjdc_pkg::WEEK_SH];
		end
	end

	// Stage 4: bump the week when the remainder reaches the weekday
	logic [8:0]           wk_rem;
	mjdc_pkg::mjdc_date_t date_s4;
	logic [8:0]           doy_s4;
	logic signed [27:0]   packed_s4;
	logic [5:0]           week_s4;

	assign wk_rem = p_s3 - {3'b0, wk0_s3} * 9'd7;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			date_s4   <= date_s3;
			doy_s4    <= doy_s3;
			packed_s4 <= packed_s3;
			week_s4   <= wk0_s3 + {5'b0, (wk_rem[2:0] >= date_s3.wday)};
		end
	end

	assign out_valid    = vld_q[N];
	assign year         = date_s4.year;
	assign month        = date_s4.month;
	assign day_of_month = date_s4.dom;
	assign weekday      = date_s4.wday;
	assign day_of_year  = doy_s4;
	assign week_of_year = week_s4;
	assign packed_date  = packed_s4;

endmodule

### sv/mjd_to_calendar_date.sv
// ----------------------------------------------------------------------------
// mjd_to_calendar_date
// Converts an integer Modified Julian Day into a calendar date with
// weekday, day of year, week number and packed yyyymmdd.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one signed 23-bit MJD per transaction; the master
//   stream returns one result transaction per input, in order. Day numbers
//   outside -2400000..2973483 are clamped. The Julian calendar applies
//   before JD 2299161, the Gregorian calendar from that day on.
//   13 register stages (divisions by constants are reciprocal multiplies);
//   the result is registered in the last stage of mjdc_date_fields.
//   Throughput is one transaction per cycle while m_tready is high;
//   conversions are independent and the block keeps no state between
//   them.
//   When the receiver deasserts m_tready, the result is held in the output
//   stage and empty stages behind it keep filling; s_tready drops only once
//   every stage holds a transaction. Nothing is dropped or repeated.
//   Reset (arst_n low) clears all stage valid bits; no transaction is in
//   flight afterwards and s_tready is high.
// ----------------------------------------------------------------------------
module mjd_to_calendar_date (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [22:0] mjd_day, [23] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // [14:0] year, [18:15] month,
	                               // [23:19] day_of_month, [26:24] weekday,
	                               // [35:27] day_of_year, [41:36] week_of_year,
	                               // [69:42] packed_date, [71:70] zero
);

	logic                 mid_valid;
	logic                 mid_ready;
	mjdc_pkg::mjdc_date_t mid_date;

	logic signed [14:0] year;
	logic [3:0]         month;
	logic [4:0]         day_of_month;
	logic [2:0]         weekday;
	logic [8:0]         day_of_year;
	logic [5:0]         week_of_year;
	logic signed [27:0] packed_date;

	// Front half: day number to year, month, day, weekday
	mjdc_day_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mjd    ($signed(s_tdata[22:0])),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_date  (mid_date)
	);

	// Back half: derived fields and output register
	mjdc_date_fields u_fields (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (mid_valid),
		.in_ready     (mid_ready),
		.in_date      (mid_date),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month),
		.weekday      (weekday),
		.day_of_year  (day_of_year),
		.week_of_year (week_of_year),
		.packed_date  (packed_date)
	);

	// Result packing, first field in the low bits
	assign m_tdata = {2'b00, packed_date, week_of_year, day_of_year, weekday,
	                  day_of_month, month, year};

	// A free-running receiver never back-pressures the input
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output is ready");

	a_month: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (month >= 4'd1 && month <= 4'd12))
		else $error("month out of range");

	a_day_wday: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (day_of_month >= 5'd1 && weekday >= 3'd1 && weekday <= 3'd7))
		else $error("day of month or weekday out of range");

	a_doy_week: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (day_of_year >= 9'd1 && day_of_year <= 9'd366 &&
		              week_of_year <= 6'd53))
		else $error("day of year or week out of range");

endmodule
